// ----- src/twg_pkg.sv -----
package twg_pkg;

   localparam int DAC_W      = 12;
   localparam int NUM_W      = 8;
   localparam int RELOAD_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int OFF_W      = 16;  // offset-binary sine, 1..65535

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SAW      = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_SELECT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_RELOAD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_CODE       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SINE_PEAK_CODE = 2'd3;

   localparam logic [RELOAD_W-1:0] RELOAD_RESET    = 16'd328;
   localparam logic [DAC_W-1:0]    TOP_RESET       = 12'd1240;
   localparam logic [DAC_W-1:0]    SINE_PEAK_RESET = 12'd4095;

   // settings captured with each emitted sample
   typedef struct packed {
      wave_type               wave;
      logic [DAC_W-1:0]       top;
      logic [DAC_W-1:0]       peak;
   } wave_cfg_type;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // Q15 sine of q/16384 quarter turns, q in 0..16384; Taylor series to x^9 in Q30
   function automatic logic [15:0] quarter_sine(input logic [14:0] q);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = ({49'd0, q} * PI_HALF_Q30) >> 14;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (((x * t) >> 30) + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s[15:0];
   endfunction

endpackage

// ----- src/twg_req_if.sv -----
interface twg_req_if ();
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

// ----- src/twg_rsp_if.sv -----
interface twg_rsp_if import twg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DAC_W-1:0] dac_code;
   logic [NUM_W-1:0] sample_number;

   modport source (output valid, output dac_code, output sample_number, input ready);
   modport sink   (input valid, input dac_code, input sample_number, output ready);
endinterface

// ----- src/twg_ram.sv -----
module twg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/twg_sine_rom.sv -----
module twg_sine_rom import twg_pkg::*; #(
   parameter int SAMPLES = 256
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(SAMPLES)-1:0] rd_addr,
   output logic [OFF_W-1:0]           rd_data
);

   typedef logic [OFF_W-1:0] rom_type [SAMPLES];

   // offset-binary sine per sample index, built at elaboration
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] p;
      logic [1:0]  quad;
      logic [14:0] r;
      logic [15:0] mag;
      for (int k = 0; k < SAMPLES; k++) begin
         p    = ((64'(k) * 64'd65536) / 64'(SAMPLES - 1)) & 64'hFFFF;
         quad = p[15:14];
         r    = {1'b0, p[13:0]};
         mag  = quad[0] ? quarter_sine(15'd16384 - r) : quarter_sine(r);
         rom[k] = quad[1] ? (16'd32768 - mag) : (16'd32768 + mag);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [OFF_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/twg_pipe.sv -----
module twg_pipe import twg_pkg::*; #(
   parameter int SAMPLES = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start_valid,
   input  logic [$clog2(SAMPLES)-1:0] start_index,
   input  wave_cfg_type               start_cfg,
   output logic                       start_ready,
   twg_rsp_if.source                  rsp
);

   localparam int IDX_W = $clog2(SAMPLES);
   localparam int XW    = IDX_W + 1 + DAC_W;   // 2*i*top
   localparam logic [IDX_W-1:0] SPAN_I = IDX_W'(SAMPLES - 1);
   localparam logic [IDX_W-1:0] HALF_I = IDX_W'(SAMPLES / 2);
   localparam logic [XW-1:0]    SPAN_X = XW'(SAMPLES - 1);
   // floor(2^XW / span); quotient estimate is exact or one low
   localparam int unsigned      RECIP_I = (2 ** XW) / (SAMPLES - 1);
   localparam logic [XW-1:0]    RECIP   = XW'(RECIP_I);

   logic take1, take2, take3, take_o;

   // stage 1
   logic             v1_ff;
   logic [IDX_W-1:0] idx1_ff;
   wave_cfg_type     cfg1_ff;
   logic [OFF_W-1:0] rom_q;

   // stage 2
   logic             v2_ff;
   logic [XW-1:0]    x2_ff;
   logic [DAC_W-1:0] direct2_ff;
   logic             div2_ff;
   logic [NUM_W-1:0] num2_ff;

   // stage 3
   logic             v3_ff;
   logic [XW-1:0]    x3_ff;
   logic [XW-1:0]    qest3_ff;
   logic [DAC_W-1:0] direct3_ff;
   logic             div3_ff;
   logic [NUM_W-1:0] num3_ff;

   // output
   logic             vo_ff;
   logic [DAC_W-1:0] dac_ff;
   logic [NUM_W-1:0] num_ff;

   logic               lower;
   logic [IDX_W-1:0]   folded;
   logic [IDX_W:0]     mult_a;
   logic [XW-1:0]      x2_in;
   logic [DAC_W+OFF_W-1:0] sine_prod;
   logic [DAC_W-1:0]   direct2_in;
   logic               div2_in;
   logic [2*XW-1:0]    recip_prod;
   logic [XW-1:0]      q_span;
   logic [XW-1:0]      rem;
   logic [XW-1:0]      quot;
   logic [DAC_W-1:0]   dac_in;

   assign take_o      = !vo_ff || rsp.ready;
   assign take3       = !v3_ff || take_o;
   assign take2       = !v2_ff || take3;
   assign take1       = !v1_ff || take2;
   assign start_ready = take1;

   twg_sine_rom #(.SAMPLES(SAMPLES)) u_rom (
      .clock   (clock),
      .rd_en   (start_valid && take1),
      .rd_addr (start_index),
      .rd_data (rom_q)
   );

   // stage 1 -> 2: products
   always_comb begin
      lower      = idx1_ff < HALF_I;
      folded     = lower ? idx1_ff : (SPAN_I - idx1_ff);
      mult_a     = (cfg1_ff.wave == WAVE_SAW) ? {1'b0, idx1_ff} : {folded, 1'b0};
      x2_in      = XW'(mult_a * cfg1_ff.top);
      sine_prod  = cfg1_ff.peak * rom_q;
      div2_in    = cfg1_ff.wave inside {WAVE_SAW, WAVE_TRIANGLE};
      case (cfg1_ff.wave)
         WAVE_SINE:   direct2_in = sine_prod[DAC_W+OFF_W-1:OFF_W];
         WAVE_SQUARE: direct2_in = lower ? cfg1_ff.top : DAC_W'(1);
         default:     direct2_in = '0;
      endcase
   end

   // stage 2 -> 3: reciprocal
   assign recip_prod = x2_ff * RECIP;

   // stage 3 -> out: one correction step
   always_comb begin
      q_span = XW'(qest3_ff * SPAN_X);
      rem    = x3_ff - q_span;
      quot   = qest3_ff + XW'(rem >= SPAN_X);
      dac_in = div3_ff ? quot[DAC_W-1:0] : direct3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (take1) begin
            v1_ff <= start_valid;
         end
         if (take2) begin
            v2_ff <= v1_ff;
         end
         if (take3) begin
            v3_ff <= v2_ff;
         end
         if (take_o) begin
            vo_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_valid && take1) begin
         idx1_ff <= start_index;
         cfg1_ff <= start_cfg;
      end
      if (v1_ff && take2) begin
         x2_ff      <= x2_in;
         direct2_ff <= direct2_in;
         div2_ff    <= div2_in;
         num2_ff    <= NUM_W'(idx1_ff);
      end
      if (v2_ff && take3) begin
         x3_ff      <= x2_ff;
         qest3_ff   <= recip_prod[2*XW-1:XW];
         direct3_ff <= direct2_ff;
         div3_ff    <= div2_ff;
         num3_ff    <= num2_ff;
      end
      if (v3_ff && take_o) begin
         dac_ff <= dac_in;
         num_ff <= num3_ff;
      end
   end

   assign rsp.valid         = vo_ff;
   assign rsp.dac_code      = dac_ff;
   assign rsp.sample_number = num_ff;

endmodule

// ----- src/table_waveform_generator.sv -----
// Table waveform generator. Each request carries one timer tick; a tick of 0
// passes no time. Ticks are counted from 0 to timer_reload, and the tick that
// finds the counter at or above timer_reload clears it and produces one
// response: a 12-bit DAC code of the selected waveform (sine, sawtooth,
// square, triangle) at the current sample index, plus that index. The index
// then advances modulo SAMPLES. A request is taken every cycle while the
// pipeline has room; the response for a wrapping tick passes through a
// four-stage pipeline (sine ROM / products, reciprocal multiply, correction,
// output register). While a response waits, ticks that
// wrap nothing keep flowing and up to three more wrapping requests are taken;
// after that the request side stalls until the response drains. The
// one-per-cycle rate is set by the read-modify-write of the counter/index
// record, held in a one-entry RAM with write-back forwarding. The record
// resets through a valid bit, so no clearing pass is needed. The sine ROM
// is built at elaboration for the chosen SAMPLES. Writing wave_select
// restarts the index; other settings apply from the next emitted sample.
module table_waveform_generator import twg_pkg::*; #(
   parameter int SAMPLES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   twg_req_if.sink               req_ch,
   twg_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(SAMPLES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

   typedef struct packed {
      logic [RELOAD_W-1:0] count;
      logic [IDX_W-1:0]    index;
   } state_type;

   // configuration registers
   wave_type            wave_ff;
   logic [RELOAD_W-1:0] reload_ff;
   logic [DAC_W-1:0]    top_ff;
   logic [DAC_W-1:0]    peak_ff;

   // state record: RAM plus forwarding of last write
   state_type ram_rd;
   state_type fwd_ff;
   logic      fwd_valid_ff;
   logic      init_ff;       // record written at least once since reset
   state_type cur_state;
   state_type state_in;
   logic      state_we;

   logic         accept;
   logic         tick_acc;
   logic         emit;
   logic         wave_wr;
   logic         pipe_ready;
   wave_cfg_type cfg_snap;

   twg_ram #(.WIDTH($bits(state_type)), .DEPTH(1)) u_state_ram (
      .clock   (clock),
      .wr_en   (state_we),
      .wr_addr (1'b0),
      .wr_data (state_in),
      .rd_addr (1'b0),
      .rd_data (ram_rd)
   );

   // latest record: write of the last edge wins over the RAM read
   always_comb begin
      if (fwd_valid_ff) begin
         cur_state = fwd_ff;
      end else if (init_ff) begin
         cur_state = ram_rd;
      end else begin
         cur_state = '0;
      end
   end

   assign req_ch.ready = pipe_ready;
   assign accept       = req_ch.valid && pipe_ready;
   assign tick_acc     = accept && req_ch.tick;
   assign emit         = tick_acc && (cur_state.count >= reload_ff);
   assign wave_wr      = csr_wr_en && (csr_index == CSR_WAVE_SELECT);

   always_comb begin
      state_in = cur_state;
      if (emit) begin
         state_in.count = '0;
         state_in.index = (cur_state.index == LAST_IDX) ? '0 : cur_state.index + 1'b1;
      end else if (tick_acc) begin
         state_in.count = cur_state.count + 1'b1;
      end
      // wave select restarts the period
      if (wave_wr) begin
         state_in.index = '0;
      end
      state_we = tick_acc || wave_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         init_ff      <= 1'b0;
      end else begin
         fwd_valid_ff <= state_we;
         if (state_we) begin
            init_ff <= 1'b1;
         end
      end
      if (state_we) begin
         fwd_ff <= state_in;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff   <= WAVE_SINE;
         reload_ff <= RELOAD_RESET;
         top_ff    <= TOP_RESET;
         peak_ff   <= SINE_PEAK_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WAVE_SELECT:    wave_ff   <= wave_type'(csr_wr_data[1:0]);
            CSR_TIMER_RELOAD:   reload_ff <= csr_wr_data[RELOAD_W-1:0];
            CSR_TOP_CODE:       top_ff    <= csr_wr_data[DAC_W-1:0];
            CSR_SINE_PEAK_CODE: peak_ff   <= csr_wr_data[DAC_W-1:0];
            default:            ;
         endcase
      end
   end

   assign cfg_snap = '{wave: wave_ff, top: top_ff, peak: peak_ff};

   twg_pipe #(.SAMPLES(SAMPLES)) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .start_valid (emit),
      .start_index (cur_state.index),
      .start_cfg   (cfg_snap),
      .start_ready (pipe_ready),
      .rsp         (rsp_ch)
   );

   // wrap clears the tick counter
   a_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> cur_state.count == '0)
      else $error("tick counter not cleared after wrap");

   // a counted tick advances the counter by exactly one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      tick_acc && !emit |=> cur_state.count == $past(cur_state.count) + 1'b1)
      else $error("tick counter did not step");

   // wave select write restarts the index
   a_wave_restart: assert property (@(posedge clock) disable iff (reset)
      wave_wr |=> cur_state.index == '0)
      else $error("sample index not restarted by wave select write");

   // index stays inside the period
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      cur_state.index <= LAST_IDX)
      else $error("sample index out of range");

endmodule

// ----- bench/table_waveform_checker.sv -----
`timescale 1ns / 1ps
module table_waveform_checker import twg_pkg::*; #(
   parameter int SAMPLES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   twg_req_if                    req_mon,
   twg_rsp_if                    rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    sample_count
);

   typedef struct packed {
      logic [DAC_W-1:0] dac_code;
      logic [NUM_W-1:0] sample_number;
   } dac_sample_type;

   // shadow of the block's settings and counters
   wave_type            wave_sel;
   logic [RELOAD_W-1:0] reload;
   logic [DAC_W-1:0]    top;
   logic [DAC_W-1:0]    peak;
   logic [RELOAD_W-1:0] ticks;
   int unsigned         index;

   dac_sample_type samples_due[$];

   // Q15 sine over a quarter turn (q/16384), Taylor terms folded from x^9 down
   function automatic logic [63:0] quarter_q15(input logic [63:0] q);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] acc;
      logic [63:0] s;
      int unsigned divs [4] = '{72, 42, 20, 6};
      x   = (q * PI_HALF_Q30) >> 14;
      x2  = (x * x) >> 30;
      acc = Q30_ONE;
      foreach (divs[k]) begin
         acc = Q30_ONE - ((x2 * acc) >> 30) / 64'(divs[k]);
      end
      s = (((x * acc) >> 30) + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s;
   endfunction

   // sine plus 32768, by quadrant symmetry
   function automatic logic [63:0] sine_biased(input int unsigned i);
      logic [63:0] phase;
      logic [1:0]  quad;
      logic [63:0] r;
      logic [63:0] mag;
      phase = ((64'(i) << 16) / 64'(SAMPLES - 1)) & 64'hFFFF;
      quad  = phase[15:14];
      r     = phase & 64'h3FFF;
      mag   = quad[0] ? quarter_q15(64'd16384 - r) : quarter_q15(r);
      return quad[1] ? 64'd32768 - mag : 64'd32768 + mag;
   endfunction

   function automatic logic [DAC_W-1:0] expected_code(input int unsigned i);
      logic [63:0] span;
      logic [63:0] v;
      span = 64'(SAMPLES - 1);
      case (wave_sel)
         WAVE_SINE:   v = (64'(peak) * sine_biased(i)) >> 16;
         WAVE_SAW:    v = (64'(i) * 64'(top)) / span;
         WAVE_SQUARE: v = (i < SAMPLES / 2) ? 64'(top) : 64'd1;
         default: begin
            if (i < SAMPLES / 2) begin
               v = (64'd2 * 64'(i) * 64'(top)) / span;
            end else begin
               v = (64'd2 * (span - 64'(i)) * 64'(top)) / span;
            end
         end
      endcase
      return v[DAC_W-1:0];
   endfunction

   task automatic flag(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      dac_sample_type got;
      dac_sample_type want;
      if (reset) begin
         wave_sel      = WAVE_SINE;
         reload        = RELOAD_RESET;
         top           = TOP_RESET;
         peak          = SINE_PEAK_RESET;
         ticks         = '0;
         index         = 0;
         fail_count    = 0;
         sample_count  = 0;
         pending_count = 0;
         samples_due.delete();
      end else begin
         // response first: it always belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.dac_code      = rsp_mon.dac_code;
            got.sample_number = rsp_mon.sample_number;
            sample_count++;
            if (samples_due.size() == 0) begin
               flag($sformatf("unexpected sample: dac_code %0d sample_number %0d",
                              got.dac_code, got.sample_number));
            end else begin
               want = samples_due.pop_front();
               if (got != want) begin
                  flag($sformatf("sample mismatch: dac_code exp %0d got %0d, %s%0d got %0d",
                                 want.dac_code, got.dac_code, "sample_number exp ",
                                 want.sample_number, got.sample_number));
               end
            end
         end
         if (req_mon.valid && req_mon.ready && req_mon.tick) begin
            if (ticks < reload) begin
               ticks = ticks + 1'b1;
            end else begin
               ticks = '0;
               if (index >= SAMPLES) begin
                  index = 0;
               end
               want.dac_code      = expected_code(index);
               want.sample_number = index[NUM_W-1:0];
               samples_due.push_back(want);
               index = (index + 1) % SAMPLES;
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WAVE_SELECT: begin
                  wave_sel = wave_type'(csr_wr_data[1:0]);
                  index    = 0;
               end
               CSR_TIMER_RELOAD:   reload = csr_wr_data[RELOAD_W-1:0];
               CSR_TOP_CODE:       top    = csr_wr_data[DAC_W-1:0];
               CSR_SINE_PEAK_CODE: peak   = csr_wr_data[DAC_W-1:0];
               default: ;
            endcase
         end
         pending_count = samples_due.size();
      end
   end

endmodule

// ----- bench/table_waveform_generator_tb.sv -----
`timescale 1ns / 1ps
module table_waveform_generator_tb import twg_pkg::*; ();

   localparam int SAMPLES       = 256;
   localparam int ITEMS_TOTAL   = 1350;
   // pipeline is four deep; leave margin for ticks that make no sample
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   int fail_count;
   int pending_count;
   int sample_count;

   // idle odds, percent of cycles; sender first, receiver second
   int req_idle_pct = 31;
   int rsp_idle_pct = 73;
   int items_sent   = 0;
   int cycle_count;

   twg_req_if req_bus ();
   twg_rsp_if rsp_bus ();

   table_waveform_generator #(
      .SAMPLES     (SAMPLES)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   table_waveform_checker #(
      .SAMPLES       (SAMPLES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .sample_count  (sample_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: ready toggles at random on the falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // hard stop in case the block hangs
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
         @(posedge clock);
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Idle schedule follows overall progress: sender busy / receiver
   // stalling, then the reverse, then both at full rate.
   task automatic update_idle_mode();
      if (items_sent < ITEMS_TOTAL / 3) begin
         req_idle_pct = 31;
         rsp_idle_pct = 73;
      end else if (items_sent < 2 * ITEMS_TOTAL / 3) begin
         req_idle_pct = 73;
         rsp_idle_pct = 31;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
   endtask

   // One tick request. Entered and left at a falling edge, so valid gets
   // exactly one assignment per time step.
   task automatic send_tick(input logic t);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.tick  <= 1'($urandom_range(1));  // noise while idle
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.tick  <= t;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // Sender holds off until every predicted sample is out, then lets the
   // pipeline flush any ticks that produce nothing.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register writes only while the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 16'($urandom);
      @(negedge clock);
   endtask

   task automatic run_phase(input int n, input int ones_pct);
      for (int k = 0; k < n; k++) begin
         update_idle_mode();
         // occasional mid-stream hold-off until the block has drained
         if ($urandom_range(199) == 0) begin
            settle();
         end
         send_tick($urandom_range(99) < ones_pct);
      end
   endtask

   // mostly short reloads so samples are frequent
   function automatic logic [RELOAD_W-1:0] pick_reload();
      int r;
      r = $urandom_range(99);
      if (r < 60) begin
         return RELOAD_W'($urandom_range(3));
      end else if (r < 90) begin
         return RELOAD_W'($urandom_range(20, 4));
      end
      return RELOAD_W'($urandom_range(40, 21));
   endfunction

   function automatic logic [DAC_W-1:0] pick_code();
      int r;
      r = $urandom_range(99);
      if (r < 15) begin
         return 12'd4095;
      end else if (r < 25) begin
         return 12'd0;
      end
      return DAC_W'($urandom_range(4095));
   endfunction

   initial begin : stimulus
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.tick  = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_WAVE_SELECT;
      csr_wr_data   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      // reset settings: ticks and idle requests, no wrap yet
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      // widest reload, count a bit more
      write_reg(CSR_TIMER_RELOAD, 16'hFFFF);
      send_tick(1'b1);
      send_tick(1'b1);
      // reload lowered below the count: next tick wraps right away
      write_reg(CSR_TIMER_RELOAD, 16'd2);
      send_tick(1'b1);
      // zero reload: every tick makes a sample, idle ticks still nothing
      write_reg(CSR_TIMER_RELOAD, 16'd0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      // sine at zero amplitude
      write_reg(CSR_SINE_PEAK_CODE, 16'hF000);
      send_tick(1'b1);
      send_tick(1'b1);
      // each waveform; the select write also restarts the index
      write_reg(CSR_WAVE_SELECT, {14'h3FFF, WAVE_SAW});
      write_reg(CSR_TOP_CODE, 16'h0FFF);
      send_tick(1'b1);
      send_tick(1'b1);
      write_reg(CSR_WAVE_SELECT, {14'd0, WAVE_SQUARE});
      write_reg(CSR_TOP_CODE, 16'hF000);
      send_tick(1'b1);
      send_tick(1'b1);
      write_reg(CSR_WAVE_SELECT, {14'd0, WAVE_TRIANGLE});
      write_reg(CSR_TOP_CODE, 16'd4095);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      write_reg(CSR_WAVE_SELECT, {14'd0, WAVE_SINE});
      write_reg(CSR_SINE_PEAK_CODE, 16'd4095);
      send_tick(1'b1);

      // --- random ---
      // first a long zero-reload run so the index walks the full period
      write_reg(CSR_TIMER_RELOAD, 16'd0);
      run_phase(300, 90);
      while (items_sent < ITEMS_TOTAL) begin
         // keep the index running across phases most of the time
         if ($urandom_range(9) < 4) begin
            write_reg(CSR_WAVE_SELECT, {14'($urandom), 2'($urandom_range(3))});
         end
         write_reg(CSR_TIMER_RELOAD, pick_reload());
         if ($urandom_range(1) == 1) begin
            write_reg(CSR_TOP_CODE, {4'($urandom), pick_code()});
         end
         if ($urandom_range(1) == 1) begin
            write_reg(CSR_SINE_PEAK_CODE, {4'($urandom), pick_code()});
         end
         run_phase($urandom_range(200, 40), $urandom_range(100, 60));
      end

      // drain and give late or stray samples a chance to show up
      settle();
      repeat (4 * SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/twg_pkg.sv
src/twg_req_if.sv
src/twg_rsp_if.sv
src/twg_ram.sv
src/twg_sine_rom.sv
src/twg_pipe.sv
src/table_waveform_generator.sv
bench/table_waveform_checker.sv
bench/table_waveform_generator_tb.sv
